[hw/rtl/point_cloud_extent_stats_core_defines.svh]
// Assertion macros for the point-set extent statistics core
`ifndef POINT_CLOUD_EXTENT_STATS_CORE_DEFINES_SVH
`define POINT_CLOUD_EXTENT_STATS_CORE_DEFINES_SVH
// implication checked every clock, muted during reset
`define PCES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, muted during reset
`define PCES_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hw/rtl/pces_pkg.sv]
// Shared constants, types and command struct for the extent statistics core
`timescale 1ns / 1ps
`default_nettype none
package pces_pkg;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 24;
  localparam int DIAM_BITS      = 25;
  localparam int COUNT_BITS     = 11;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // store a point and update running stats
    logic clear;      // return running stats to their reset values
    logic pair_start; // begin pair walk: i = 0, j = 1, best = 0
    logic pair_step;  // issue read for (i, j) and advance
    logic sqrt_start; // start root of best squared distance
    logic div_start;  // start centroid division
    logic capture;    // latch result into output register
  } pces_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic full;       // store holds MAX_POINTS points
    logic pair_done;  // all pairs issued
    logic pipe_empty; // distance pipeline drained
    logic sqrt_busy;
    logic div_busy;
  } pces_sts_t;
endpackage
`default_nettype wire

[hw/rtl/pces_ctrl.sv]
// Controller state machine for the extent statistics core
`timescale 1ns / 1ps
`default_nettype none
module pces_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            last_point,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  input  wire pces_pkg::pces_sts_t sts,
  output pces_pkg::pces_cmd_t  cmd
);
  import pces_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PAIR  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MATH  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic       xfer_in;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT);
  assign xfer_in   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        cmd.load = xfer_in && !sts.full;
        if (xfer_in && last_point) begin
          cmd.pair_start = 1'b1;
          state_next = S_PAIR;
        end
      end
      S_PAIR: begin
        if (sts.pair_done) state_next = S_DRAIN;
        else cmd.pair_step = 1'b1;
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.sqrt_start = 1'b1;
          cmd.div_start  = 1'b1;
          state_next = S_MATH;
        end
      end
      S_MATH: state_next = S_WAIT;
      S_WAIT: begin
        if (!sts.sqrt_busy && !sts.div_busy) begin
          cmd.capture = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end
endmodule
`default_nettype wire

[hw/rtl/pces_dp.sv]
// Datapath: point memory, running stats, pair walk, root and centroid units
`timescale 1ns / 1ps
`default_nettype none
module pces_dp #(
  parameter int MAX_POINTS = pces_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pces_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pces_pkg::pces_cmd_t           cmd,
  output pces_pkg::pces_sts_t                sts,
  input  wire logic signed [COORD_BITS-1:0]  point_x,
  input  wire logic signed [COORD_BITS-1:0]  point_y,
  input  wire logic signed [COORD_BITS-1:0]  point_z,
  output logic [pces_pkg::DIAM_BITS-1:0]     diameter,
  output logic signed [COORD_BITS-1:0]       min_x,
  output logic signed [COORD_BITS-1:0]       min_y,
  output logic signed [COORD_BITS-1:0]       min_z,
  output logic signed [COORD_BITS-1:0]       max_x,
  output logic signed [COORD_BITS-1:0]       max_y,
  output logic signed [COORD_BITS-1:0]       max_z,
  output logic signed [COORD_BITS-1:0]       centroid_x,
  output logic signed [COORD_BITS-1:0]       centroid_y,
  output logic signed [COORD_BITS-1:0]       centroid_z,
  output logic [pces_pkg::COUNT_BITS-1:0]    point_count,
  output logic                               overflowed
);
  import pces_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = AW + 1;
  localparam int DW   = COORD_BITS + 1;           // difference width
  localparam int SQW  = 2 * DW;                   // square width
  localparam int DSW  = SQW + 2;                  // sum of three squares
  localparam int RW   = (DSW + 1) / 2;            // root width
  localparam int SW   = COORD_BITS + CW;          // axis sum width
  localparam int QW   = SW;                       // magnitude quotient width
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam int PW = 3 * COORD_BITS;

  // point memory, two read ports
  logic [PW-1:0] mem [MAX_POINTS];
  logic [PW-1:0] rd_a, rd_b;

  logic [CW-1:0] count;
  logic          drop;
  logic signed [COORD_BITS-1:0] mn [3];
  logic signed [COORD_BITS-1:0] mx [3];
  logic signed [SW-1:0]         sum [3];
  logic signed [COORD_BITS-1:0] pin [3];

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;
  assign sts.full = (count == CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (cmd.load) mem[count[AW-1:0]] <= {point_x, point_y, point_z};
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      drop  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        mn[a]  <= CMAX;
        mx[a]  <= CMIN;
        sum[a] <= '0;
      end
    end else if (cmd.load) begin
      count <= count + 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (pin[a] < mn[a]) mn[a] <= pin[a];
        if (pin[a] > mx[a]) mx[a] <= pin[a];
        sum[a] <= sum[a] + SW'(pin[a]);
      end
    end else if (cmd.pair_start && !sts.full) begin
      // last point dropped only when full; otherwise counted by load
    end
    if (!rst && !cmd.clear && cmd.pair_start && sts.full && !cmd.load) drop <= 1'b1;
    else if (!rst && !cmd.clear && sts.full && cmd.load) drop <= 1'b1;
  end

  // pair walk: i < j < count
  logic [CW-1:0] pi, pj;
  logic          walk_done;
  always_ff @(posedge clk) begin
    if (cmd.pair_start) begin
      pi <= '0;
      pj <= CW'(1);
    end else if (cmd.pair_step) begin
      if (pj + 1'b1 >= count) begin
        pi <= pi + 1'b1;
        pj <= pi + CW'(2);
      end else begin
        pj <= pj + 1'b1;
      end
    end
  end
  assign walk_done = (pi + 1'b1 >= count) || (pj >= count);
  assign sts.pair_done = walk_done;

  // pipeline: read -> diff -> square -> sum -> compare
  logic v0, v1, v2, v3;
  always_ff @(posedge clk) begin
    if (cmd.pair_step) begin
      rd_a <= mem[pi[AW-1:0]];
      rd_b <= mem[pj[AW-1:0]];
    end
  end

  logic [DW-1:0]   dmag [3];
  logic [SQW-1:0]  sq [3];
  logic [DSW-1:0]  dsq, best;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic signed [DW-1:0] d;
      d = DW'($signed(rd_a[(2-a)*COORD_BITS +: COORD_BITS]))
        - DW'($signed(rd_b[(2-a)*COORD_BITS +: COORD_BITS]));
      dmag[a] <= d[DW-1] ? DW'(-d) : DW'(d);
    end
    for (int a = 0; a < 3; a++) sq[a] <= dmag[a] * dmag[a];
    dsq <= DSW'(sq[0]) + DSW'(sq[1]) + DSW'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      v0 <= cmd.pair_step; v1 <= v0; v2 <= v1; v3 <= v2;
    end
  end
  assign sts.pipe_empty = !(v0 || v1 || v2 || v3);

  always_ff @(posedge clk) begin
    if (cmd.pair_start) best <= '0;
    else if (v3 && dsq > best) best <= dsq;
  end

  // restoring square root, one result bit per cycle
  logic [DSW+1:0] rem;
  logic [DSW-1:0] rad;
  logic [RW-1:0]  root;
  logic [$clog2(RW+1)-1:0] scnt;
  logic           sbusy;
  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sbusy <= 1'b1;
      rem   <= '0;
      root  <= '0;
      rad   <= best;
      scnt  <= ($clog2(RW+1))'(RW);
    end else if (sbusy) begin
      logic [DSW+1:0] r2, t;
      r2 = {rem[DSW-1:0], rad[DSW-1:DSW-2]};
      t  = {root, 2'b01};
      rad <= {rad[DSW-3:0], 2'b00};
      if (r2 >= t) begin
        rem  <= r2 - t;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[RW-2:0], 1'b0};
      end
      scnt <= scnt - 1'b1;
      if (scnt == ($clog2(RW+1))'(1)) sbusy <= 1'b0;
    end
  end
  assign sts.sqrt_busy = sbusy;

  // restoring divider, one quotient bit per cycle, three axes in parallel
  logic [QW-1:0]  dq  [3];
  logic [CW-1:0]  drem[3];
  logic           dneg[3];
  logic [$clog2(QW+1)-1:0] dcnt;
  logic           dbusy;
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dcnt  <= ($clog2(QW+1))'(QW);
      for (int a = 0; a < 3; a++) begin
        dneg[a] <= sum[a][SW-1];
        dq[a]   <= sum[a][SW-1] ? QW'(-sum[a]) : QW'(sum[a]);
        drem[a] <= '0;
      end
    end else if (dbusy) begin
      for (int a = 0; a < 3; a++) begin
        logic [CW:0] tr;
        tr = {drem[a], dq[a][QW-1]};
        if (tr >= {1'b0, count}) begin
          drem[a] <= CW'(tr - {1'b0, count});
          dq[a]   <= {dq[a][QW-2:0], 1'b1};
        end else begin
          drem[a] <= tr[CW-1:0];
          dq[a]   <= {dq[a][QW-2:0], 1'b0};
        end
      end
      dcnt <= dcnt - 1'b1;
      if (dcnt == ($clog2(QW+1))'(1)) dbusy <= 1'b0;
    end
  end
  assign sts.div_busy = dbusy;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diameter    <= DIAM_BITS'(root);
      min_x <= mn[0]; min_y <= mn[1]; min_z <= mn[2];
      max_x <= mx[0]; max_y <= mx[1]; max_z <= mx[2];
      centroid_x  <= dneg[0] ? COORD_BITS'(-dq[0]) : COORD_BITS'(dq[0]);
      centroid_y  <= dneg[1] ? COORD_BITS'(-dq[1]) : COORD_BITS'(dq[1]);
      centroid_z  <= dneg[2] ? COORD_BITS'(-dq[2]) : COORD_BITS'(dq[2]);
      point_count <= COUNT_BITS'(count);
      overflowed  <= drop;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/point_cloud_extent_stats_core.sv]
// Top level of the point-set extent statistics core
//  channel | direction | handshake             | payload
//  point   | in        | in_valid / in_ready   | point_x/y/z, last_point
//  result  | out       | out_valid / out_ready | diameter, min/max, centroid, count
// Points load one per cycle into a dual-read point memory while in_ready is high.
// After the last point, the pair walk issues one pair per cycle, then the distance pipeline
// drains and a bit-serial root and divider run.
// Input is held off from the last point until the result transfer completes.
// Reset clears counts and stats; the point memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_extent_stats_core #(
  parameter int MAX_POINTS = pces_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pces_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  point_x,
  input  wire logic signed [COORD_BITS-1:0]  point_y,
  input  wire logic signed [COORD_BITS-1:0]  point_z,
  input  wire logic                          last_point,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pces_pkg::DIAM_BITS-1:0]     diameter,
  output logic signed [COORD_BITS-1:0]       min_x,
  output logic signed [COORD_BITS-1:0]       min_y,
  output logic signed [COORD_BITS-1:0]       min_z,
  output logic signed [COORD_BITS-1:0]       max_x,
  output logic signed [COORD_BITS-1:0]       max_y,
  output logic signed [COORD_BITS-1:0]       max_z,
  output logic signed [COORD_BITS-1:0]       centroid_x,
  output logic signed [COORD_BITS-1:0]       centroid_y,
  output logic signed [COORD_BITS-1:0]       centroid_z,
  output logic [pces_pkg::COUNT_BITS-1:0]    point_count,
  output logic                               overflowed
);
  import pces_pkg::*;

  pces_cmd_t cmd;
  pces_sts_t sts;

  pces_ctrl u_ctrl (
    .clk, .rst, .in_valid, .last_point, .in_ready,
    .out_ready, .out_valid, .sts, .cmd
  );

  pces_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .point_x, .point_y, .point_z,
    .diameter, .min_x, .min_y, .min_z, .max_x, .max_y, .max_z,
    .centroid_x, .centroid_y, .centroid_z, .point_count, .overflowed
  );
endmodule
`default_nettype wire

[hw/rtl/pces_checker.sv]
// Port-level assertion checker for the extent statistics core, with bind
`timescale 1ns / 1ps
`default_nettype none
`include "point_cloud_extent_stats_core_defines.svh"
module pces_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        last_point,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] point_count,
  input wire logic [24:0] diameter
);
  `PCES_ASSERT_IMP(a_no_in_while_out, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `PCES_ASSERT_NXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(diameter), "result dropped or changed while stalled")
  `PCES_ASSERT_NXT(a_last_blocks, clk, rst, in_valid && in_ready && last_point, !in_ready, "input reopened right after last point")
  `PCES_ASSERT_IMP(a_count_nonzero, clk, rst, out_valid, point_count != 11'd0, "result with zero points")
endmodule

bind point_cloud_extent_stats_core pces_checker u_pces_checker (
  .clk, .rst, .in_valid, .in_ready, .last_point, .out_valid, .out_ready,
  .point_count, .diameter
);
`default_nettype wire

[test/pces_extent_checker.sv]
// Checker for the point-set extent statistics core: predicts each set's result and compares
`timescale 1ns / 1ps
module pces_extent_checker #(
  parameter int MAX_POINTS = pces_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pces_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       point_x,
  input  logic signed [COORD_BITS-1:0]       point_y,
  input  logic signed [COORD_BITS-1:0]       point_z,
  input  logic                               last_point,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [pces_pkg::DIAM_BITS-1:0]     diameter,
  input  logic signed [COORD_BITS-1:0]       min_x,
  input  logic signed [COORD_BITS-1:0]       min_y,
  input  logic signed [COORD_BITS-1:0]       min_z,
  input  logic signed [COORD_BITS-1:0]       max_x,
  input  logic signed [COORD_BITS-1:0]       max_y,
  input  logic signed [COORD_BITS-1:0]       max_z,
  input  logic signed [COORD_BITS-1:0]       centroid_x,
  input  logic signed [COORD_BITS-1:0]       centroid_y,
  input  logic signed [COORD_BITS-1:0]       centroid_z,
  input  logic [pces_pkg::COUNT_BITS-1:0]    point_count,
  input  logic                               overflowed,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 sets_seen
);
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));

  typedef struct {
    logic [pces_pkg::DIAM_BITS-1:0]  diam;
    logic signed [COORD_BITS-1:0]    lo[3];
    logic signed [COORD_BITS-1:0]    hi[3];
    logic signed [COORD_BITS-1:0]    mean[3];
    logic [pces_pkg::COUNT_BITS-1:0] cnt;
    logic                            dropped;
  } extent_t;

  longint  set_pts[MAX_POINTS][3];
  int      set_size;
  longint  run_lo[3], run_hi[3], run_sum[3];
  bit      set_dropped;
  extent_t extents_due[$];

  function automatic void clear_set();
    set_size = 0;
    set_dropped = 0;
    for (int a = 0; a < 3; a++) begin
      run_lo[a] = COORD_MAX;
      run_hi[a] = COORD_MIN;
      run_sum[a] = 0;
    end
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void absorb_point(longint px, longint py, longint pz, bit fin);
    longint p[3];
    longint unsigned best, d2, root;
    longint dd, q;
    extent_t e;
    p[0] = px; p[1] = py; p[2] = pz;
    if (set_size < MAX_POINTS) begin
      for (int a = 0; a < 3; a++) begin
        set_pts[set_size][a] = p[a];
        if (p[a] < run_lo[a]) run_lo[a] = p[a];
        if (p[a] > run_hi[a]) run_hi[a] = p[a];
        run_sum[a] += p[a];
      end
      set_size++;
    end else begin
      set_dropped = 1;
    end
    if (!fin) return;
    best = 0;
    for (int i = 0; i + 1 < set_size; i++)
      for (int j = i + 1; j < set_size; j++) begin
        d2 = 0;
        for (int a = 0; a < 3; a++) begin
          dd = set_pts[i][a] - set_pts[j][a];
          d2 += longint'(dd * dd);
        end
        if (d2 > best) best = d2;
      end
    root = floor_root(best);
    e.diam = root[pces_pkg::DIAM_BITS-1:0];
    for (int a = 0; a < 3; a++) begin
      e.lo[a] = run_lo[a][COORD_BITS-1:0];
      e.hi[a] = run_hi[a][COORD_BITS-1:0];
      q = run_sum[a] / longint'(set_size);  // truncates toward zero
      e.mean[a] = q[COORD_BITS-1:0];
    end
    e.cnt = set_size[pces_pkg::COUNT_BITS-1:0];
    e.dropped = set_dropped;
    extents_due.push_back(e);
    clear_set();
  endfunction

  function automatic void check_field(string fname, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    sets_seen = 0;
    pending = 0;
    clear_set();
  end

  always @(posedge clk) begin
    extent_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        absorb_point(longint'(point_x), longint'(point_y), longint'(point_z), last_point);
      if (out_valid && out_ready) begin
        sets_seen++;
        if (extents_due.size() == 0) begin
          $display("%0t: unexpected result transfer, diameter %0d", $time, diameter);
          fail_count++;
        end else begin
          e = extents_due.pop_front();
          check_field("diameter", e.diam, diameter);
          check_field("min_x", e.lo[0], min_x);
          check_field("min_y", e.lo[1], min_y);
          check_field("min_z", e.lo[2], min_z);
          check_field("max_x", e.hi[0], max_x);
          check_field("max_y", e.hi[1], max_y);
          check_field("max_z", e.hi[2], max_z);
          check_field("centroid_x", e.mean[0], centroid_x);
          check_field("centroid_y", e.mean[1], centroid_y);
          check_field("centroid_z", e.mean[2], centroid_z);
          check_field("point_count", e.cnt, point_count);
          check_field("overflowed", e.dropped, overflowed);
        end
      end
    end
    pending = extents_due.size();
  end
endmodule

[test/tb_point_cloud_extent_stats_core.sv]
// Testbench top for the point-set extent statistics core: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_point_cloud_extent_stats_core;
  localparam int NPTS = pces_pkg::MAX_POINTS_DEF;
  localparam int CB   = pces_pkg::COORD_BITS_DEF;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [CB-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic last_point = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [pces_pkg::DIAM_BITS-1:0] diameter;
  logic signed [CB-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  logic signed [CB-1:0] centroid_x, centroid_y, centroid_z;
  logic [pces_pkg::COUNT_BITS-1:0] point_count;
  logic overflowed;
  int fail_count, pending, sets_seen;
  int points_sent;
  bit calm;
  int stall_left;

  always #5 clk = ~clk;

  point_cloud_extent_stats_core u_top (.*);

  pces_extent_checker u_chk (.*);

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return CMAX;
    if (r == 1) return CMIN;
    if (r < 5) return CB'($urandom_range(0, 200) - 100);
    return CB'($urandom());
  endfunction

  // output side stalls
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= !rst;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 3) begin
      out_ready <= 0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1;
    end
  end

  task automatic send_point(logic signed [CB-1:0] x, y, z, logic fin);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    last_point <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  task automatic send_random_set(int n);
    for (int k = 0; k < n; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
  endtask

  initial begin
    points_sent = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single points at both extremes
    send_point(CMAX, CMAX, CMAX, 1);
    send_point(CMIN, CMIN, CMIN, 1);
    // opposite corners: largest possible diameter
    send_point(CMIN, CMIN, CMIN, 0);
    send_point(CMAX, CMAX, CMAX, 1);
    // negative sums that need truncation toward zero
    send_point(-3, -1, 5, 0);
    send_point(0, 0, 0, 1);
    send_point(-7, 7, -1, 0);
    send_point(0, 1, 0, 0);
    send_point(1, 0, -1, 1);
    // identical points: zero diameter with several points
    send_point(24'sh12345, -24'sh1, 24'sh800, 0);
    send_point(24'sh12345, -24'sh1, 24'sh800, 1);
    send_random_set(5);

    // fill the store, then drop one ordinary and one last point
    calm = 1;
    for (int k = 0; k < NPTS; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(), 0);
    calm = 0;
    send_point(CMAX, CMIN, 0, 0);
    send_point(CMIN, CMAX, 1, 1);

    // hold off until the big set has been reported
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // random sets, mostly small
    while (points_sent < NPTS + 30 + 600) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      if ($urandom_range(0, 9) == 0) send_random_set($urandom_range(20, 48));
      else send_random_set($urandom_range(1, 8));
      if ($urandom_range(0, 24) == 0) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    calm = 0;
    in_valid <= 0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d points, %0d sets reported, incl. full-store drops and extreme corners.",
             points_sent, sets_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_point_cloud_extent_stats_core OK");
    end else begin
      $display("tb_point_cloud_extent_stats_core NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("tb_point_cloud_extent_stats_core NOT OK");
    $finish;
  end
endmodule
